// ===== rtl/timed_cover_position_tracker_unit_macros.svh =====
// Assertion macros shared by the cover position tracker RTL.
// Included by the top level; needs clk and rst_n in the including scope.
`ifndef TIMED_COVER_POSITION_TRACKER_UNIT_MACROS_SVH
`define TIMED_COVER_POSITION_TRACKER_UNIT_MACROS_SVH

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define TCTU_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tracker assertion failed");

// Whenever the antecedent holds, the consequent holds in the next cycle.
`define TCTU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tracker assertion failed");

`endif

// ===== rtl/tctu_pkg.sv =====
// Shared types and constants for the cover position tracker.
// No dependencies; every other RTL module and interface imports this package.
`default_nettype none

package tctu_pkg;

    localparam int POSITION_BITS = 24;
    localparam int POS_W         = POSITION_BITS + 1;
    localparam int STEP_W        = 25;
    localparam int SUM_W         = ((POS_W > STEP_W) ? POS_W : STEP_W) + 1;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_W         = STEP_W;

    // Fully open, 1.0 in Q1.POSITION_BITS.
    localparam logic [POS_W-1:0]  POS_ONE    = {1'b1, {POSITION_BITS{1'b0}}};
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(280);

    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_STEP  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_STEP = 1'b1;

    typedef enum logic [1:0] {
        REQ_TICK = 2'd0,
        REQ_STOP = 2'd1,
        REQ_MOVE = 2'd2,
        REQ_PROG = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        MOT_IDLE    = 2'd0,
        MOT_OPENING = 2'd1,
        MOT_CLOSING = 2'd2
    } motion_t;

    typedef enum logic [2:0] {
        CMD_NONE = 3'd0,
        CMD_MY   = 3'd1,
        CMD_UP   = 3'd2,
        CMD_DOWN = 3'd3,
        CMD_PROG = 3'd4
    } cmd_t;

    typedef struct packed {
        req_type_t        req_type;
        logic [POS_W-1:0] target_position;
    } req_item_t;

    typedef struct packed {
        cmd_t             command;
        logic [POS_W-1:0] position;
        motion_t          operation;
    } res_item_t;

endpackage

`default_nettype wire

// ===== rtl/tctu_req_if.sv =====
// Request channel: valid/ready handshake carrying one request word.
// Depends on tctu_pkg for field widths.
`default_nettype none

interface tctu_req_if;
    import tctu_pkg::*;

    logic             valid;
    logic             ready;
    logic [1:0]       req_type;
    logic [POS_W-1:0] target_position;

    modport source (output valid, output req_type, output target_position, input ready);
    modport sink (input valid, input req_type, input target_position, output ready);
endinterface

`default_nettype wire

// ===== rtl/tctu_res_if.sv =====
// Result channel: valid/ready handshake carrying one result word.
// Depends on tctu_pkg for field widths.
`default_nettype none

interface tctu_res_if;
    import tctu_pkg::*;

    logic             valid;
    logic             ready;
    logic [2:0]       command;
    logic [POS_W-1:0] position;
    logic [1:0]       operation;

    modport source (output valid, output command, output position, output operation,
                    input ready);
    modport sink (input valid, input command, input position, input operation,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/tctu_in_stage.sv =====
// Input register of the tracker: captures one request word per handshake.
// Depends on tctu_pkg and tctu_req_if.
`default_nettype none

module tctu_in_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    tctu_req_if.sink             req,
    input  logic                 advance,
    output logic                 item_valid,
    output tctu_pkg::req_item_t  item
);
    import tctu_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    logic      take;
    req_item_t item_reg;

    assign req.ready  = !valid_reg || advance;
    assign take       = req.valid && req.ready;
    assign valid_next = take ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.req_type        <= req_type_t'(req.req_type);
            item_reg.target_position <= req.target_position;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;
endmodule

`default_nettype wire

// ===== rtl/tctu_tracker.sv =====
// Position state, step registers and next-state logic of the tracker.
// Depends on tctu_pkg.
`default_nettype none

module tctu_tracker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [tctu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tctu_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          fire,
    input  tctu_pkg::req_item_t           item,
    output tctu_pkg::res_item_t           result
);
    import tctu_pkg::*;

    logic [STEP_W-1:0] open_step_reg;
    logic [STEP_W-1:0] close_step_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [POS_W-1:0]  goal_reg;
    logic [POS_W-1:0]  goal_next;
    motion_t           motion_reg;
    motion_t           motion_next;
    cmd_t              cmd;

    logic [SUM_W-1:0]  open_sum;
    logic [POS_W-1:0]  pos_tick;
    logic              reached;
    logic              goal_end;
    logic [POS_W-1:0]  target_sat;
    logic              move_goal_set;
    motion_t           move_motion;

    assign open_sum = SUM_W'(pos_reg) + SUM_W'(open_step_reg);
    assign goal_end = (goal_reg == '0) || (goal_reg == POS_ONE);

    // Position after one millisecond of travel, clamped to both ends.
    always_comb
    begin
        unique case (motion_reg)
            MOT_OPENING:
                pos_tick = (open_sum > SUM_W'(POS_ONE)) ? POS_ONE : open_sum[POS_W-1:0];
            MOT_CLOSING:
                pos_tick = (SUM_W'(close_step_reg) >= SUM_W'(pos_reg)) ? '0
                         : POS_W'(SUM_W'(pos_reg) - SUM_W'(close_step_reg));
            default:
                pos_tick = pos_reg;
        endcase
    end

    always_comb
    begin
        unique case (motion_reg)
            MOT_OPENING: reached = (pos_tick >= goal_reg);
            MOT_CLOSING: reached = (pos_tick <= goal_reg);
            default:     reached = 1'b1;
        endcase
    end

    // A move to the current position only re-commands an end position.
    assign target_sat = (item.target_position > POS_ONE) ? POS_ONE : item.target_position;

    always_comb
    begin
        move_goal_set = 1'b1;
        move_motion   = (target_sat < pos_reg) ? MOT_CLOSING : MOT_OPENING;
        if (target_sat == pos_reg)
        begin
            if (target_sat == '0)
            begin
                move_motion = MOT_CLOSING;
            end
            else if (target_sat == POS_ONE)
            begin
                move_motion = MOT_OPENING;
            end
            else
            begin
                move_goal_set = 1'b0;
                move_motion   = motion_reg;
            end
        end
    end

    always_comb
    begin
        pos_next    = pos_reg;
        goal_next   = goal_reg;
        motion_next = motion_reg;
        cmd         = CMD_NONE;
        unique case (item.req_type)
            REQ_TICK:
            begin
                pos_next = pos_tick;
                if (reached)
                begin
                    motion_next = MOT_IDLE;
                    if (motion_reg != MOT_IDLE && !goal_end)
                    begin
                        cmd = CMD_MY;
                    end
                end
            end
            REQ_STOP:
            begin
                motion_next = MOT_IDLE;
                if (motion_reg != MOT_IDLE)
                begin
                    cmd = CMD_MY;
                end
            end
            REQ_MOVE:
            begin
                if (move_goal_set)
                begin
                    goal_next = target_sat;
                end
                if (move_motion != motion_reg)
                begin
                    motion_next = move_motion;
                    cmd         = (move_motion == MOT_OPENING) ? CMD_UP : CMD_DOWN;
                end
            end
            REQ_PROG:
            begin
                cmd = CMD_PROG;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_step_reg  <= STEP_RESET;
            close_step_reg <= STEP_RESET;
            pos_reg        <= '0;
            goal_reg       <= '0;
            motion_reg     <= MOT_IDLE;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_OPEN_STEP)
            begin
                open_step_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == CFG_CLOSE_STEP)
            begin
                close_step_reg <= cfg_data;
            end
            if (fire)
            begin
                pos_reg    <= pos_next;
                goal_reg   <= goal_next;
                motion_reg <= motion_next;
            end
        end
    end

    assign result.command   = cmd;
    assign result.position  = pos_next;
    assign result.operation = motion_next;
endmodule

`default_nettype wire

// ===== rtl/tctu_out_stage.sv =====
// Result register of the tracker: holds one result word until it is taken.
// Depends on tctu_pkg and tctu_res_if.
`default_nettype none

module tctu_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  tctu_pkg::res_item_t  item,
    output logic                 can_load,
    tctu_res_if.source           res
);
    import tctu_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    res_item_t item_reg;

    assign can_load   = !valid_reg || res.ready;
    assign valid_next = load ? 1'b1 : (res.ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item;
        end
    end

    assign res.valid     = valid_reg;
    assign res.command   = item_reg.command;
    assign res.position  = item_reg.position;
    assign res.operation = item_reg.operation;
endmodule

`default_nettype wire

// ===== rtl/timed_cover_position_tracker_unit.sv =====
// Top level of the time-based cover position tracker.
// Depends on tctu_pkg, both interfaces, the stages, the tracker and the macro header.
`default_nettype none

// The tracker estimates a motorized blind's position from travel time. Each request
// word is a one-millisecond tick, a stop, a move to a Q1.24 target (1.0 = fully open,
// larger targets saturate to open) or a program request, and each produces exactly one
// result word: the radio command to send (none, my/stop, up, down, prog), the position
// after the request and the motion state. Ticks move the estimate by open_step or
// close_step, clamped to closed and open; reaching the goal stops the motion, with a
// stop command only when the goal lies between the ends. A tick, stop or move that
// leaves the direction unchanged sends no command, while a move to an end already
// reached sends it again. Throughput is one word per clock while the result side takes
// words; a stalled result register holds the word in the input register. A word waits
// in the input register, and its whole update (one add, clamp and compare) runs
// combinationally from there into the result register. The position, goal and motion
// registers update as the word moves into the result register, so the next word sees them.
// Step registers are index 0 (open_step) and 1 (close_step), written whenever cfg_we is
// high; write them only while no word is in flight. There is no clearing pass.
module timed_cover_position_tracker_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tctu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tctu_pkg::CFG_W-1:0]     cfg_data,
    tctu_req_if.sink                       req,
    tctu_res_if.source                     res
);
    import tctu_pkg::*;

    // The input register hands its word on whenever the result register can take it,
    // which keeps both sides moving at one word per cycle while results are taken.
    logic      item_valid;
    req_item_t item;
    logic      can_load;
    logic      advance;
    res_item_t result;

    // A result word that carries a motion command, and whether the command matches
    // the motion state reported beside it.
    logic      motion_cmd;
    logic      cmd_agrees;

    assign advance = item_valid && can_load;

    tctu_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // Position, goal and motion update exactly when a word moves to the result side.
    tctu_tracker u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fire      (advance),
        .item      (item),
        .result    (result)
    );

    tctu_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .item     (result),
        .can_load (can_load),
        .res      (res)
    );

    assign motion_cmd = res.valid && (res.command != CMD_NONE) && (res.command != CMD_PROG);
    assign cmd_agrees = ((res.command == CMD_UP) && (res.operation == MOT_OPENING))
                     || ((res.command == CMD_DOWN) && (res.operation == MOT_CLOSING))
                     || ((res.command == CMD_MY) && (res.operation == MOT_IDLE));

`include "timed_cover_position_tracker_unit_macros.svh"

    // The reported position never leaves the closed-to-open range.
    `TCTU_ASSERT_SAME(a_position_range, res.valid, res.position <= POS_ONE)
    // A motion command always agrees with the motion state reported beside it.
    `TCTU_ASSERT_SAME(a_command_motion, motion_cmd, cmd_agrees)
    // With both registers full and the result stalled, no new word may enter.
    `TCTU_ASSERT_SAME(a_full_stall, item_valid && res.valid && !res.ready, !req.ready)
    // A word that moves into the result register always shows up as valid there.
    `TCTU_ASSERT_NEXT(a_advance_valid, advance, res.valid)

endmodule

`default_nettype wire
